[design/slil_pkg.sv]
// Shared constants and controller/datapath interface types for the sorted list core.
package slil_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int KEY_WIDTH_DEF = 16;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic load;
    logic probe;
    logic cmp;
    logic settle;
    logic shift;
    logic write_key;
    logic finish;
  } slil_cmd_t;

  typedef struct packed {
    logic range_open;
    logic hit;
    logic insert;
    logic full;
    logic shift_done;
    logic out_free;
  } slil_status_t;

endpackage

[design/slil_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module slil_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/slil_ctrl.sv]
// Controller state machine that sequences search, shift and result hand-off.
module slil_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  slil_pkg::slil_status_t status,
  output slil_pkg::slil_cmd_t   cmd
);

  import slil_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_CMP    = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_WRITE  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (status.insert && status.full) begin
          state_nxt = S_DONE;
        end else if (status.range_open) begin
          cmd.probe = 1'b1;
          state_nxt = S_CMP;
        end else begin
          cmd.settle = 1'b1;
          state_nxt  = status.insert ? S_SHIFT : S_DONE;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = status.hit ? S_DONE : S_SEARCH;
      end
      S_SHIFT: begin
        if (status.shift_done) begin
          state_nxt = S_WRITE;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_WRITE: begin
        cmd.write_key = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/slil_dp.sv]
// Datapath: search bounds, shift pointer, key memory and output register.
module slil_dp #(
  parameter int DEPTH     = slil_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = slil_pkg::KEY_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  slil_pkg::slil_cmd_t        cmd,
  output slil_pkg::slil_status_t     status,
  input  logic                       in_op,
  input  logic [KEY_WIDTH-1:0]       in_key,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_found,
  output logic                       out_overflow,
  output logic [$clog2(DEPTH+1)-1:0] out_position,
  output logic [$clog2(DEPTH+1)-1:0] out_entry_total
);

  import slil_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  logic [CW-1:0]        count_r;
  logic [CW-1:0]        lo_r;
  logic [CW-1:0]        hi_r;
  logic [CW-1:0]        mid_r;
  logic [CW-1:0]        pos_r;
  logic [CW-1:0]        ptr_r;
  logic [AW-1:0]        pend_addr_r;
  logic                 pend_r;
  logic                 op_r;
  logic                 found_r;
  logic                 ovf_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic                 out_valid_r;
  logic                 out_found_r;
  logic                 out_ovf_r;
  logic [CW-1:0]        out_pos_r;
  logic [CW-1:0]        out_total_r;

  logic [CW:0]          mid_sum;
  logic [CW-1:0]        mid_calc;
  logic [CW-1:0]        ptr_m1;
  logic                 full;
  logic                 key_eq;
  logic                 go_right;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [KEY_WIDTH-1:0] ram_rdata;

  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r} - {{CW{1'b0}}, 1'b1};
  assign mid_calc = mid_sum[CW:1];
  assign ptr_m1   = ptr_r - {{(CW-1){1'b0}}, 1'b1};
  assign full     = (count_r == CW'(DEPTH));
  assign key_eq   = (ram_rdata == key_r);
  assign go_right = (op_r == OP_INSERT) ? (ram_rdata <= key_r) : (ram_rdata < key_r);

  assign ram_raddr = cmd.shift ? ptr_m1[AW-1:0] : mid_calc[AW-1:0];
  assign ram_we    = (cmd.shift && pend_r) || cmd.write_key;
  assign ram_waddr = cmd.write_key ? pos_r[AW-1:0] : pend_addr_r;
  assign ram_wdata = cmd.write_key ? key_r : ram_rdata;

  slil_ram #(
    .WIDTH(KEY_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    status            = '0;
    status.range_open = (lo_r < hi_r);
    status.hit        = (op_r == OP_LOOKUP) && key_eq;
    status.insert     = (op_r == OP_INSERT);
    status.full       = full;
    status.shift_done = (ptr_r == pos_r) && !pend_r;
    status.out_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        op_r    <= in_op;
        key_r   <= in_key;
        lo_r    <= '0;
        hi_r    <= count_r;
        pos_r   <= '0;
        found_r <= 1'b0;
        ovf_r   <= (in_op == OP_INSERT) && full;
        pend_r  <= 1'b0;
      end
      if (cmd.probe) begin
        mid_r <= mid_calc;
      end
      if (cmd.cmp) begin
        if ((op_r == OP_LOOKUP) && key_eq) begin
          found_r <= 1'b1;
          pos_r   <= mid_r;
        end else if (go_right) begin
          lo_r <= mid_r + {{(CW-1){1'b0}}, 1'b1};
        end else begin
          hi_r <= mid_r;
        end
      end
      if (cmd.settle) begin
        pos_r <= lo_r;
        ptr_r <= count_r;
      end
      if (cmd.shift) begin
        if (ptr_r != pos_r) begin
          ptr_r       <= ptr_m1;
          pend_r      <= 1'b1;
          pend_addr_r <= ptr_r[AW-1:0];
        end else begin
          pend_r <= 1'b0;
        end
      end
      if (cmd.write_key) begin
        count_r <= count_r + {{(CW-1){1'b0}}, 1'b1};
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
        out_found_r <= found_r;
        out_ovf_r   <= ovf_r;
        out_pos_r   <= pos_r;
        out_total_r <= count_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_overflow    = out_ovf_r;
  assign out_position    = out_pos_r;
  assign out_entry_total = out_total_r;

endmodule

[design/sorted_list_insert_lookup_core.sv]
// Sorted key list core with binary-search lookup and order-keeping insert.
// The core keeps up to DEPTH keys in ascending order in one RAM with a
// registered read port, and handles one item at a time. Every item returns
// one result. Each search probe has two steps (address, then compare), and
// there are at most ceil(log2(n+1)) probes for n stored keys. An insert adds
// the shift of the n - slot later entries at one RAM read and one RAM write
// per cycle, then writes the key. A refused insert into a full list skips
// the search. A new item is taken while the previous result still waits in
// the output register.
module sorted_list_insert_lookup_core #(
  parameter int DEPTH     = slil_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = slil_pkg::KEY_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // [0] operation
  input  logic                                    in_tuser,
  // [KEY_WIDTH-1:0] key, zero padded to bytes
  input  logic [((KEY_WIDTH+7)/8)*8-1:0]          in_tdata,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // [0] found, [1] overflow
  output logic [1:0]                              out_tuser,
  // position, then entry_total, each $clog2(DEPTH+1) bits, zero padded to bytes
  output logic [((2*$clog2(DEPTH+1)+7)/8)*8-1:0]  out_tdata
);

  import slil_pkg::*;

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int OUT_W = ((2 * CW + 7) / 8) * 8;

  slil_cmd_t    cmd;
  slil_status_t status;
  logic [CW-1:0] position;
  logic [CW-1:0] entry_total;

  slil_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  slil_dp #(
    .DEPTH    (DEPTH),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_op          (in_tuser),
    .in_key         (in_tdata[KEY_WIDTH-1:0]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_found      (out_tuser[0]),
    .out_overflow   (out_tuser[1]),
    .out_position   (position),
    .out_entry_total(entry_total)
  );

  assign out_tdata = OUT_W'({entry_total, position});

endmodule

[design/slil_checker.sv]
// Port-level assertions for the sorted list core, bound to the top level.
module slil_checker #(
  parameter int DEPTH     = slil_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = slil_pkg::KEY_WIDTH_DEF
) (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   out_tvalid,
  input logic                                   out_tready,
  input logic [1:0]                             out_tuser,
  input logic [((2*$clog2(DEPTH+1)+7)/8)*8-1:0] out_tdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = KEY_WIDTH;

  logic [CW-1:0] position;
  logic [CW-1:0] entry_total;

  assign position    = out_tdata[CW-1:0];
  assign entry_total = out_tdata[2*CW-1:CW];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  a_ovf_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0] && position == '0)
    else $error("refused insert reports found or a position");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> entry_total == CW'(DEPTH))
    else $error("refused insert while list not full");

  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && KW > 0 |-> entry_total <= CW'(DEPTH) && position <= entry_total)
    else $error("position or entry total out of range");

endmodule

bind sorted_list_insert_lookup_core slil_checker #(
  .DEPTH    (DEPTH),
  .KEY_WIDTH(KEY_WIDTH)
) u_slil_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tuser (out_tuser),
  .out_tdata (out_tdata)
);

[test/sorted_list_insert_lookup_core_test.sv]
// Self-checking stream testbench for the sorted list lookup/insert core.
module sorted_list_insert_lookup_core_test;
  import slil_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1830;
  localparam int QUIET_ITEMS = 200;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic       found;
    logic       overflow;
    logic [6:0] position;
    logic [6:0] entry_total;
  } list_result_t;

  typedef struct packed {
    logic         typed;
    logic         op;
    logic [15:0]  key;
    list_result_t result;
  } directed_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic        in_tuser = OP_LOOKUP;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [1:0]  out_tuser;
  logic [15:0] out_tdata;

  logic [15:0]  stored_keys [LIST_DEPTH];
  int           stored_count = 0;
  list_result_t pending_results [$];
  int           mismatches = 0;
  int           results_seen = 0;
  int           cycle_count = 0;
  bit           quiet = 1'b0;

  directed_row_t directed_rows [0:19] = '{
    '{1'b1, OP_LOOKUP, 16'h0000, '{1'b0, 1'b0, 7'd0, 7'd0}},
    '{1'b1, OP_LOOKUP, 16'hFFFF, '{1'b0, 1'b0, 7'd0, 7'd0}},
    '{1'b1, OP_INSERT, 16'h8000, '{1'b0, 1'b0, 7'd0, 7'd1}},
    '{1'b1, OP_INSERT, 16'h0000, '{1'b0, 1'b0, 7'd0, 7'd2}},
    '{1'b1, OP_INSERT, 16'hFFFF, '{1'b0, 1'b0, 7'd2, 7'd3}},
    '{1'b1, OP_INSERT, 16'h8000, '{1'b0, 1'b0, 7'd2, 7'd4}},
    '{1'b0, OP_LOOKUP, 16'h8000, '0},
    '{1'b0, OP_LOOKUP, 16'h0000, '0},
    '{1'b0, OP_LOOKUP, 16'hFFFF, '0},
    '{1'b0, OP_LOOKUP, 16'h7FFF, '0},
    '{1'b0, OP_LOOKUP, 16'h8001, '0},
    '{1'b1, OP_INSERT, 16'hFFFF, '{1'b0, 1'b0, 7'd4, 7'd5}},
    '{1'b1, OP_INSERT, 16'h0000, '{1'b0, 1'b0, 7'd1, 7'd6}},
    '{1'b0, OP_INSERT, 16'h5555, '0},
    '{1'b0, OP_INSERT, 16'hAAAA, '0},
    '{1'b0, OP_LOOKUP, 16'h5555, '0},
    '{1'b0, OP_LOOKUP, 16'hAAAA, '0},
    '{1'b0, OP_LOOKUP, 16'h0001, '0},
    '{1'b0, OP_LOOKUP, 16'hFFFE, '0},
    '{1'b0, OP_INSERT, 16'h8000, '0}
  };

  sorted_list_insert_lookup_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic list_result_t apply_list_item(input logic op, input logic [15:0] key);
    list_result_t r;
    int lo;
    int hi;
    int mid;
    r = '0;
    lo = 0;
    hi = stored_count - 1;
    if (op == OP_LOOKUP) begin
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (stored_keys[mid] == key) begin
          r.found = 1'b1;
          r.position = 7'(mid);
          break;
        end
        if (stored_keys[mid] < key) lo = mid + 1;
        else hi = mid - 1;
      end
      if (!r.found) r.position = 7'(lo);
    end else if (stored_count >= LIST_DEPTH) begin
      r.overflow = 1'b1;
    end else begin
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (stored_keys[mid] <= key) lo = mid + 1;
        else hi = mid - 1;
      end
      for (int i = stored_count; i > lo; i--) stored_keys[i] = stored_keys[i-1];
      stored_keys[lo] = key;
      stored_count++;
      r.position = 7'(lo);
    end
    r.entry_total = 7'(stored_count);
    return r;
  endfunction

  task automatic offer_item(input logic op, input logic [15:0] key, input logic typed,
                            input list_result_t typed_result);
    list_result_t r;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= key;
    do @(posedge clk); while (!in_tready);
    r = apply_list_item(op, key);
    pending_results = {pending_results, typed ? typed_result : r};
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] pick_insert_key();
    case ($urandom_range(0, 2))
      0: return 16'($urandom_range(0, 31));
      1: return 16'($urandom);
      default: return $urandom_range(0, 1) ? 16'hFFFF - 16'($urandom_range(0, 7))
                                            : 16'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [15:0] pick_lookup_key();
    int pick;
    logic [15:0] k;
    pick = $urandom_range(0, 9);
    if (stored_count == 0 || pick >= 7) return pick_insert_key();
    k = stored_keys[$urandom_range(0, stored_count - 1)];
    if (pick == 5) return k + 16'd1;
    if (pick == 6) return k - 16'd1;
    return k;
  endfunction

  // stimulus
  initial begin
    logic op;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i])
      offer_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].typed,
                 directed_rows[i].result);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      op = ($urandom_range(0, 19) == 0) ? OP_INSERT : OP_LOOKUP;
      offer_item(op, op == OP_INSERT ? pick_insert_key() : pick_lookup_key(), 1'b0, '0);
    end
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // receiver: random stalls plus one long hold-off to back up the core
  initial begin
    bit held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && results_seen >= 50) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser[0], out_tuser[1], out_tdata[6:0], out_tdata[13:7]};
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item found=%0d overflow=%0d position=%0d entry_total=%0d",
                 $time, got.found, got.overflow, got.position, got.entry_total);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found) begin
          $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
          mismatches++;
        end
        if (got.overflow !== want.overflow) begin
          $display("%0t: overflow expected %0d actual %0d", $time, want.overflow, got.overflow);
          mismatches++;
        end
        if (got.position !== want.position) begin
          $display("%0t: position expected %0d actual %0d", $time, want.position, got.position);
          mismatches++;
        end
        if (got.entry_total !== want.entry_total) begin
          $display("%0t: entry_total expected %0d actual %0d", $time, want.entry_total,
                   got.entry_total);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d items outstanding", $time, pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
